FILE: rtl/core/chp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// chp_pkg
// Shared types and fixed widths for the convex hull perimeter block.
// ---------------------------------------------------------------------------
package chp_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int DIST_W  = 2 * COORD_W + 2;
    localparam int FRAC_W  = 8;
    localparam int SQ_W    = DIST_W + 2 * FRAC_W;
    localparam int ROOT_W  = SQ_W / 2 + 1;
    localparam int PERIM_W = 36;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_point;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } t_point_in;

    typedef struct packed {
        logic [PERIM_W-1:0] perimeter;
        logic               overflow;
    } t_result;

    typedef struct packed {
        logic   start;
        t_point o;
        t_point a;
        t_point b;
    } t_geom_req;

    typedef struct packed {
        logic              done;
        logic              pos;
        logic              zero;
        logic              lt;
        logic [DIST_W-1:0] da;
    } t_geom_res;

endpackage

`default_nettype wire

FILE: rtl/core/chp_stream_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// chp_stream_if
// Valid/ready channel carrying one beat of payload type T.
// ---------------------------------------------------------------------------
interface chp_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/convex_hull_perimeter.sv
`default_nettype none
// ---------------------------------------------------------------------------
// convex_hull_perimeter
// Graham scan hull perimeter over a point set held in block RAM.
// Points load at one beat per cycle while the block is in its load state (ready
// is low otherwise). After the last point the block runs an anchor search, a
// heap sort of the points by angle (n log n sift steps, each with up to two
// compares through the geometry pipeline), the scan steps, and one iterative
// 25-step square root per hull edge.
// Sets of fewer than three points give a zero perimeter without the hull search.
// Reset (synchronous, active low) clears control state; RAM is not cleared.
// ---------------------------------------------------------------------------
module convex_hull_perimeter #(
    parameter int MAX_POINTS = 1024
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    chp_stream_if.sink   i_pt,
    chp_stream_if.source o_res
);
    import chp_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int XW    = CNT_W + 1;

    typedef logic [XW-1:0] t_ix;

    localparam logic [4:0] S_LOAD  = 5'd0,  S_MIN0 = 5'd1,  S_MIN  = 5'd2,
                           S_SWP0  = 5'd3,  S_SWP1 = 5'd4,  S_HB   = 5'd5,
                           S_SB    = 5'd6,  S_SB1  = 5'd7,  S_CHK  = 5'd8,
                           S_C1    = 5'd9,  S_C2   = 5'd10, S_G1   = 5'd11,
                           S_G2    = 5'd12, S_EC   = 5'd13, S_E0   = 5'd14,
                           S_E1    = 5'd15, S_SC0  = 5'd16, S_SC1  = 5'd17,
                           S_SRD   = 5'd18, S_SG0  = 5'd19, S_ST   = 5'd20,
                           S_SW    = 5'd21, S_SPR  = 5'd22, S_PRD  = 5'd23,
                           S_PD    = 5'd24, S_PG   = 5'd25, S_PQ   = 5'd26,
                           S_EMIT  = 5'd27;

    function automatic logic [IDX_W-1:0] arr_a(input t_ix k);
        t_ix s;
        s = k + 1'b1;
        return s[IDX_W-1:0];
    endfunction

    // control
    logic [4:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic             r_out_valid, n_out_valid;
    t_geom_req        r_greq, n_greq;
    logic             r_build, n_build;
    logic             r_last, n_last;
    // datapath
    t_ix              r_i, n_i, r_ridx, n_ridx, r_low, n_low;
    t_ix              r_root, n_root, r_end, n_end, r_child, n_child, r_depth, n_depth;
    t_point           r_lowv, n_lowv, r_p0, n_p0, r_anchor, n_anchor;
    t_point           r_vr, n_vr, r_vc, n_vc, r_vc1, n_vc1;
    t_point           r_top, n_top, r_sec, n_sec, r_pi, n_pi, r_prev, n_prev, r_cur, n_cur;
    logic [PERIM_W-1:0] r_sum, n_sum;
    t_result          r_out, n_out;

    // memories
    logic             pm_we, pm_re, sm_we, sm_re;
    logic [IDX_W-1:0] pm_wa, pm_ra, sm_wa, sm_ra;
    t_point           pm_wd, pm_rd, sm_wd, sm_rd;

    t_geom_res        g_res;
    logic             sq_start, sq_done;
    logic [ROOT_W-1:0] sq_root;

    t_ix              w_n, w_m, w_c2;
    logic             w_before;
    logic [PERIM_W:0] w_acc;
    t_point           w_in_pt;

    chp_ram #(.W(2*COORD_W), .DEPTH(MAX_POINTS)) u_pts (
        .i_clk(i_clk), .i_we(pm_we), .i_waddr(pm_wa), .i_wdata(pm_wd),
        .i_re(pm_re), .i_raddr(pm_ra), .o_rdata(pm_rd)
    );

    chp_ram #(.W(2*COORD_W), .DEPTH(MAX_POINTS)) u_stk (
        .i_clk(i_clk), .i_we(sm_we), .i_waddr(sm_wa), .i_wdata(sm_wd),
        .i_re(sm_re), .i_raddr(sm_ra), .o_rdata(sm_rd)
    );

    chp_geom u_geom (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_greq), .o_res(g_res));

    chp_isqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start), .i_val(g_res.da),
        .o_done(sq_done), .o_root(sq_root)
    );

    assign w_n      = XW'(r_cnt);
    assign w_m      = w_n - 1'b1;
    assign w_c2     = {r_root[XW-2:0], 1'b1};
    assign w_before = g_res.zero ? g_res.lt : g_res.pos;
    assign w_acc    = {1'b0, r_sum} + (PERIM_W+1)'(sq_root);
    assign w_in_pt  = '{y: i_pt.data.point_y, x: i_pt.data.point_x};

    assign i_pt.ready  = (r_state == S_LOAD);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_comb begin
        n_state = r_state;  n_cnt = r_cnt;   n_ovf = r_ovf;
        n_out_valid = r_out_valid && !o_res.ready;
        n_greq = r_greq;    n_greq.start = 1'b0;
        n_build = r_build;  n_last = r_last;
        n_i = r_i;  n_ridx = r_ridx;  n_low = r_low;  n_root = r_root;
        n_end = r_end;  n_child = r_child;  n_depth = r_depth;
        n_lowv = r_lowv;  n_p0 = r_p0;  n_anchor = r_anchor;
        n_vr = r_vr;  n_vc = r_vc;  n_vc1 = r_vc1;  n_top = r_top;  n_sec = r_sec;
        n_pi = r_pi;  n_prev = r_prev;  n_cur = r_cur;  n_sum = r_sum;  n_out = r_out;
        pm_we = 1'b0;  pm_wa = '0;  pm_wd = w_in_pt;  pm_re = 1'b0;  pm_ra = '0;
        sm_we = 1'b0;  sm_wa = '0;  sm_wd = r_pi;     sm_re = 1'b0;  sm_ra = '0;
        sq_start = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                if (i_pt.valid) begin
                    if (w_n < XW'(MAX_POINTS)) begin
                        pm_we = 1'b1;
                        pm_wa = r_cnt[IDX_W-1:0];
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_pt.data.last_point) begin
                        n_sum = '0;
                        if (n_cnt < CNT_W'(3)) begin
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_MIN0;
                        end
                    end
                end
            end
            S_MIN0: begin
                pm_re   = 1'b1;
                pm_ra   = '0;
                n_ridx  = '0;
                n_i     = t_ix'(1);
                n_state = S_MIN;
            end
            S_MIN: begin
                if (r_ridx == '0) begin
                    n_p0   = pm_rd;
                    n_lowv = pm_rd;
                    n_low  = '0;
                end else if (pm_rd.y < r_lowv.y ||
                             (pm_rd.y == r_lowv.y && pm_rd.x < r_lowv.x)) begin
                    n_lowv = pm_rd;
                    n_low  = r_ridx;
                end
                if (r_i < w_n) begin
                    pm_re  = 1'b1;
                    pm_ra  = r_i[IDX_W-1:0];
                    n_ridx = r_i;
                    n_i    = r_i + 1'b1;
                end
                if (r_ridx == w_m) begin
                    n_state = S_SWP0;
                end
            end
            S_SWP0: begin
                pm_we   = 1'b1;
                pm_wa   = r_low[IDX_W-1:0];
                pm_wd   = r_p0;
                n_state = S_SWP1;
            end
            S_SWP1: begin
                pm_we    = 1'b1;
                pm_wa    = '0;
                pm_wd    = r_lowv;
                n_anchor = r_lowv;
                n_greq.o = r_lowv;
                n_i      = w_m >> 1;
                n_state  = S_HB;
            end
            S_HB: begin
                if (r_i == '0) begin
                    n_end   = w_m;
                    n_state = S_EC;
                end else begin
                    n_i     = r_i - 1'b1;
                    n_root  = r_i - 1'b1;
                    n_end   = w_m;
                    n_build = 1'b1;
                    n_state = S_SB;
                end
            end
            S_SB: begin
                pm_re   = 1'b1;
                pm_ra   = arr_a(r_root);
                n_state = S_SB1;
            end
            S_SB1: begin
                n_vr    = pm_rd;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (w_c2 < r_end) begin
                    n_child = w_c2;
                    pm_re   = 1'b1;
                    pm_ra   = arr_a(w_c2);
                    n_state = S_C1;
                end else begin
                    pm_we   = 1'b1;
                    pm_wa   = arr_a(r_root);
                    pm_wd   = r_vr;
                    n_state = r_build ? S_HB : S_EC;
                end
            end
            S_C1: begin
                n_vc = pm_rd;
                if (r_child + 1'b1 < r_end) begin
                    pm_re   = 1'b1;
                    pm_ra   = arr_a(r_child + 1'b1);
                    n_state = S_C2;
                end else begin
                    n_greq  = '{start: 1'b1, o: r_anchor, a: r_vr, b: pm_rd};
                    n_state = S_G2;
                end
            end
            S_C2: begin
                n_vc1   = pm_rd;
                n_greq  = '{start: 1'b1, o: r_anchor, a: r_vc, b: pm_rd};
                n_state = S_G1;
            end
            S_G1: begin
                if (g_res.done) begin
                    if (w_before) begin
                        n_child = r_child + 1'b1;
                        n_vc    = r_vc1;
                    end
                    n_greq  = '{start: 1'b1, o: r_anchor, a: r_vr, b: n_vc};
                    n_state = S_G2;
                end
            end
            S_G2: begin
                if (g_res.done) begin
                    pm_we = 1'b1;
                    pm_wa = arr_a(r_root);
                    if (w_before) begin
                        pm_wd   = r_vc;
                        n_root  = r_child;
                        n_state = S_CHK;
                    end else begin
                        pm_wd   = r_vr;
                        n_state = r_build ? S_HB : S_EC;
                    end
                end
            end
            S_EC: begin
                if (r_end > t_ix'(1)) begin
                    pm_re   = 1'b1;
                    pm_ra   = arr_a('0);
                    n_state = S_E0;
                end else begin
                    n_state = S_SC0;
                end
            end
            S_E0: begin
                n_vc    = pm_rd;
                pm_re   = 1'b1;
                pm_ra   = arr_a(r_end - 1'b1);
                n_state = S_E1;
            end
            S_E1: begin
                n_vr    = pm_rd;
                pm_we   = 1'b1;
                pm_wa   = arr_a(r_end - 1'b1);
                pm_wd   = r_vc;
                n_end   = r_end - 1'b1;
                n_root  = '0;
                n_build = 1'b0;
                n_state = S_CHK;
            end
            S_SC0: begin
                sm_we   = 1'b1;
                sm_wa   = '0;
                sm_wd   = r_anchor;
                pm_re   = 1'b1;
                pm_ra   = IDX_W'(1);
                n_state = S_SC1;
            end
            S_SC1: begin
                sm_we   = 1'b1;
                sm_wa   = IDX_W'(1);
                sm_wd   = pm_rd;
                n_top   = pm_rd;
                n_sec   = r_anchor;
                n_depth = t_ix'(2);
                n_i     = t_ix'(2);
                n_state = S_SRD;
            end
            S_SRD: begin
                if (r_i == w_n) begin
                    n_prev  = r_anchor;
                    n_i     = t_ix'(1);
                    n_last  = 1'b0;
                    n_state = S_PRD;
                end else begin
                    pm_re   = 1'b1;
                    pm_ra   = r_i[IDX_W-1:0];
                    n_state = S_SG0;
                end
            end
            S_SG0: begin
                n_pi    = pm_rd;
                n_state = S_ST;
            end
            S_ST: begin
                if (r_depth > t_ix'(1)) begin
                    n_greq  = '{start: 1'b1, o: r_sec, a: r_top, b: r_pi};
                    n_state = S_SW;
                end else begin
                    sm_we   = 1'b1;
                    sm_wa   = r_depth[IDX_W-1:0];
                    n_sec   = r_top;
                    n_top   = r_pi;
                    n_depth = r_depth + 1'b1;
                    n_i     = r_i + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_SW: begin
                if (g_res.done) begin
                    if (!g_res.pos) begin
                        n_depth = r_depth - 1'b1;
                        n_top   = r_sec;
                        if (r_depth > t_ix'(2)) begin
                            sm_re   = 1'b1;
                            sm_ra   = IDX_W'(r_depth - t_ix'(3));
                            n_state = S_SPR;
                        end else begin
                            n_state = S_ST;
                        end
                    end else begin
                        sm_we   = 1'b1;
                        sm_wa   = r_depth[IDX_W-1:0];
                        n_sec   = r_top;
                        n_top   = r_pi;
                        n_depth = r_depth + 1'b1;
                        n_i     = r_i + 1'b1;
                        n_state = S_SRD;
                    end
                end
            end
            S_SPR: begin
                n_sec   = sm_rd;
                n_state = S_ST;
            end
            S_PRD: begin
                if (r_i < r_depth) begin
                    sm_re   = 1'b1;
                    sm_ra   = r_i[IDX_W-1:0];
                    n_state = S_PD;
                end else begin
                    n_cur   = r_anchor;
                    n_last  = 1'b1;
                    n_greq  = '{start: 1'b1, o: r_prev, a: r_anchor, b: r_anchor};
                    n_state = S_PG;
                end
            end
            S_PD: begin
                n_cur   = sm_rd;
                n_greq  = '{start: 1'b1, o: r_prev, a: sm_rd, b: sm_rd};
                n_state = S_PG;
            end
            S_PG: begin
                if (g_res.done) begin
                    sq_start = 1'b1;
                    n_state  = S_PQ;
                end
            end
            S_PQ: begin
                if (sq_done) begin
                    n_sum   = w_acc[PERIM_W] ? '1 : w_acc[PERIM_W-1:0];
                    n_prev  = r_cur;
                    n_i     = r_i + 1'b1;
                    n_state = r_last ? S_EMIT : S_PRD;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = '{perimeter: r_sum, overflow: r_ovf};
                    n_cnt       = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_greq      <= '0;
            r_build     <= 1'b0;
            r_last      <= 1'b0;
            r_sum       <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_greq      <= n_greq;
            r_build     <= n_build;
            r_last      <= n_last;
            r_sum       <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;  r_ridx <= n_ridx;  r_low <= n_low;  r_root <= n_root;
        r_end <= n_end;  r_child <= n_child;  r_depth <= n_depth;
        r_lowv <= n_lowv;  r_p0 <= n_p0;  r_anchor <= n_anchor;
        r_vr <= n_vr;  r_vc <= n_vc;  r_vc1 <= n_vc1;
        r_top <= n_top;  r_sec <= n_sec;  r_pi <= n_pi;
        r_prev <= n_prev;  r_cur <= n_cur;  r_out <= n_out;
    end
endmodule

`default_nettype wire

FILE: rtl/core/chp_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// chp_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module chp_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [W-1:0]             i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]            o_rdata
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

`default_nettype wire

FILE: rtl/core/chp_geom.sv
`default_nettype none
// ---------------------------------------------------------------------------
// chp_geom
// Four-stage pipeline: cross product of (a-o, b-o) and squared distances
// |a-o|^2, |b-o|^2 with their compare.
// ---------------------------------------------------------------------------
module chp_geom (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  chp_pkg::t_geom_req i_req,
    output chp_pkg::t_geom_res o_res
);
    import chp_pkg::*;

    logic [2:0]               r_vld;
    logic signed [DIFF_W-1:0] r_dax, r_day, r_dbx, r_dby;
    logic signed [PROD_W-1:0] r_p1, r_p2, r_sa1, r_sa2, r_sb1, r_sb2;
    logic signed [PROD_W:0]   r_cr, r_da, r_db;
    logic                     r_done, r_pos, r_zero, r_lt;
    logic [DIST_W-1:0]        r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[1:0], i_req.start};
            r_done <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dax <= {i_req.a.x[COORD_W-1], i_req.a.x} - {i_req.o.x[COORD_W-1], i_req.o.x};
        r_day <= {i_req.a.y[COORD_W-1], i_req.a.y} - {i_req.o.y[COORD_W-1], i_req.o.y};
        r_dbx <= {i_req.b.x[COORD_W-1], i_req.b.x} - {i_req.o.x[COORD_W-1], i_req.o.x};
        r_dby <= {i_req.b.y[COORD_W-1], i_req.b.y} - {i_req.o.y[COORD_W-1], i_req.o.y};
        r_p1  <= r_dax * r_dby;
        r_p2  <= r_dbx * r_day;
        r_sa1 <= r_dax * r_dax;
        r_sa2 <= r_day * r_day;
        r_sb1 <= r_dbx * r_dbx;
        r_sb2 <= r_dby * r_dby;
        r_cr  <= (PROD_W+1)'(r_p1) - (PROD_W+1)'(r_p2);
        r_da  <= (PROD_W+1)'(r_sa1) + (PROD_W+1)'(r_sa2);
        r_db  <= (PROD_W+1)'(r_sb1) + (PROD_W+1)'(r_sb2);
        r_pos  <= r_cr > 0;
        r_zero <= r_cr == 0;
        r_lt   <= r_da < r_db;
        r_dist <= r_da[DIST_W-1:0];
    end

    assign o_res = '{done: r_done, pos: r_pos, zero: r_zero, lt: r_lt, da: r_dist};
endmodule

`default_nettype wire

FILE: rtl/core/chp_isqrt.sv
`default_nettype none
// ---------------------------------------------------------------------------
// chp_isqrt
// Iterative floor(sqrt(d * 2^16)), one result bit per cycle.
// ---------------------------------------------------------------------------
module chp_isqrt (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire [chp_pkg::DIST_W-1:0]   i_val,
    output logic                        o_done,
    output logic [chp_pkg::ROOT_W-1:0]  o_root
);
    import chp_pkg::*;

    logic            r_busy, r_done;
    logic [SQ_W-1:0] r_v, r_res, r_bit;
    logic [SQ_W-1:0] w_try;

    assign w_try = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_bit[0];
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_bit[0]) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= {i_val, {(2*FRAC_W){1'b0}}};
            r_res <= '0;
            r_bit <= SQ_W'(1) << (SQ_W - 2);
        end else if (r_busy) begin
            if (r_v >= w_try) begin
                r_v   <= r_v - w_try;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];
endmodule

`default_nettype wire
